// ----- hw/rtl/lmc_instruction_execute_core_defines.svh -----
// Assertion macros for the LMC execute core.
`ifndef LMC_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH
`define LMC_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LMC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lmc_pkg.sv -----
`default_nettype none
package lmc_pkg;

  localparam int MEM_DEPTH_DEF = 128;
  localparam int ADDR_W        = 7;
  localparam int WORD_W        = 10;
  localparam int ACC_W         = 32;
  localparam int PC_W          = 16;
  localparam int OP_W          = 4;
  localparam int STATUS_W      = 3;

  localparam int IN_TDATA_W    = 56;
  localparam int OUT_TDATA_W   = 48;
  localparam int OUT_TUSER_W   = 4;

  localparam logic signed [ACC_W-1:0] STA_MAX = 32'sd999;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_STA = 4'd2,
    OP_LDA = 4'd3,
    OP_BRA = 4'd4,
    OP_BRZ = 4'd5,
    OP_BRP = 4'd6,
    OP_INP = 4'd7,
    OP_OUT = 4'd8,
    OP_HLT = 4'd9
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACC_CHANGED   = 3'd0,
    ST_ACC_UNCHANGED = 3'd1,
    ST_BRANCHED      = 3'd2,
    ST_HALT          = 3'd3,
    ST_ERROR         = 3'd4,
    ST_LOADED        = 3'd5
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lmc_instruction_execute_core.sv -----
// Result path: an input transfer fills the input register, then the result register; the result
// transfer follows. Throughput: one instruction or preload per cycle unless out_tready stalls;
// the accumulator loop is one add and compare.
// Memory read data is registered at input transfer, with bypass of the write made that cycle.
// Reset (rst_n low, synchronous): accumulator and PC clear, all memory words read as zero
// through per-word valid bits cleared at once; no clearing pass is needed before ready.
`default_nettype none
`include "lmc_instruction_execute_core_defines.svh"
module lmc_instruction_execute_core #(
  parameter int MEM_DEPTH = lmc_pkg::MEM_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // opcode[3:0], address[10:4], load_word[20:11], typed_value[52:21], zero[55:53]
  input  wire logic [lmc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // acc_now[31:0], pc_now[47:32]
  output logic [lmc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // status[2:0], print_valid[3]
  output logic [lmc_pkg::OUT_TUSER_W-1:0]      out_tuser
);

  localparam int ADDR_W    = lmc_pkg::ADDR_W;
  localparam int WORD_W    = lmc_pkg::WORD_W;
  localparam int ACC_W     = lmc_pkg::ACC_W;
  localparam int PC_W      = lmc_pkg::PC_W;
  localparam int OP_W      = lmc_pkg::OP_W;
  localparam int ADDR_SPAN = 2 ** ADDR_W;
  localparam int MEM_N     = (MEM_DEPTH < ADDR_SPAN) ? MEM_DEPTH : ADDR_SPAN;
  localparam int IDX_W     = $clog2(MEM_N);
  localparam logic [ADDR_W:0] MEM_LIM = (ADDR_W + 1)'(MEM_N);

  localparam int OP_LO  = 0;
  localparam int ADR_LO = OP_LO + OP_W;
  localparam int LW_LO  = ADR_LO + ADDR_W;
  localparam int TV_LO  = LW_LO + WORD_W;

  logic                      in_xfer;
  logic [ADDR_W-1:0]         in_addr;
  logic                      in_rng;
  logic [IDX_W-1:0]          rd_idx;

  logic                      s1_valid_r;
  logic                      s1_kind_r;
  logic [OP_W-1:0]           s1_op_r;
  logic [ADDR_W-1:0]         s1_addr_r;
  logic [WORD_W-1:0]         s1_load_r;
  logic signed [ACC_W-1:0]   s1_typed_r;
  logic                      s1_rng;
  logic                      s1_adv;

  logic [WORD_W-1:0]         mem [MEM_N];
  logic [MEM_N-1:0]          mem_vld_r;
  logic [WORD_W-1:0]         mem_q_r;
  logic                      rd_ok_r;
  logic                      fwd_r;
  logic [WORD_W-1:0]         fwd_data_r;
  logic [WORD_W-1:0]         s1_word;

  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic [PC_W-1:0]           pc_r;
  logic [PC_W-1:0]           pc_nxt;
  logic [PC_W-1:0]           pc_inc;
  logic [ACC_W:0]            sum;
  logic                      ovf;
  lmc_pkg::status_t          ex_status;
  logic                      ex_print;
  logic                      wr_req;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_idx;
  logic [WORD_W-1:0]         wr_data;

  logic                      out_valid_r;
  logic [lmc_pkg::STATUS_W-1:0] out_status_r;
  logic                      out_print_r;
  logic [ACC_W-1:0]          out_acc_r;
  logic [PC_W-1:0]           out_pc_r;

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_addr   = in_tdata[ADR_LO +: ADDR_W];
  assign in_rng    = {1'b0, in_addr} < MEM_LIM;
  assign rd_idx    = in_addr[IDX_W-1:0];
  assign s1_rng    = {1'b0, s1_addr_r} < MEM_LIM;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r  <= in_tuser;
      s1_op_r    <= in_tdata[OP_LO +: OP_W];
      s1_addr_r  <= in_addr;
      s1_load_r  <= in_tdata[LW_LO +: WORD_W];
      s1_typed_r <= in_tdata[TV_LO +: ACC_W];
    end
  end

  // Word memory, registered read with write bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (in_xfer) begin
      mem_q_r    <= mem[rd_idx];
      rd_ok_r    <= in_rng && mem_vld_r[rd_idx];
      fwd_r      <= wr_en && (wr_idx == rd_idx) && in_rng;
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
    end else if (wr_en) begin
      mem_vld_r[wr_idx] <= 1'b1;
    end
  end

  assign s1_word = fwd_r ? fwd_data_r : (rd_ok_r ? mem_q_r : '0);

  // Execute
  assign pc_inc = pc_r + PC_W'(1);
  assign wr_idx = s1_addr_r[IDX_W-1:0];
  assign wr_en  = s1_adv && wr_req && s1_rng;

  always_comb begin
    if (s1_op_r == lmc_pkg::OP_SUB) begin
      sum = {acc_r[ACC_W-1], acc_r} - {{(ACC_W + 1 - WORD_W){1'b0}}, s1_word};
    end else begin
      sum = {acc_r[ACC_W-1], acc_r} + {{(ACC_W + 1 - WORD_W){1'b0}}, s1_word};
    end
    ovf = sum[ACC_W] ^ sum[ACC_W-1];
  end

  always_comb begin
    acc_nxt   = acc_r;
    pc_nxt    = pc_r;
    ex_status = lmc_pkg::ST_ERROR;
    ex_print  = 1'b0;
    wr_req    = 1'b0;
    wr_data   = s1_load_r;
    if (s1_kind_r) begin
      wr_req    = 1'b1;
      ex_status = lmc_pkg::ST_LOADED;
    end else begin
      case (s1_op_r)
        lmc_pkg::OP_ADD, lmc_pkg::OP_SUB: begin
          if (!ovf) begin
            acc_nxt   = sum[ACC_W-1:0];
            pc_nxt    = pc_inc;
            ex_status = lmc_pkg::ST_ACC_CHANGED;
          end
        end
        lmc_pkg::OP_STA: begin
          wr_data = acc_r[WORD_W-1:0];
          if (!acc_r[ACC_W-1] && (acc_r <= lmc_pkg::STA_MAX)) begin
            wr_req    = 1'b1;
            pc_nxt    = pc_inc;
            ex_status = lmc_pkg::ST_ACC_UNCHANGED;
          end
        end
        lmc_pkg::OP_LDA: begin
          acc_nxt   = {{(ACC_W - WORD_W){1'b0}}, s1_word};
          pc_nxt    = pc_inc;
          ex_status = lmc_pkg::ST_ACC_CHANGED;
        end
        lmc_pkg::OP_BRA: begin
          pc_nxt    = {{(PC_W - ADDR_W){1'b0}}, s1_addr_r};
          ex_status = lmc_pkg::ST_BRANCHED;
        end
        lmc_pkg::OP_BRZ, lmc_pkg::OP_BRP: begin
          if ((s1_op_r == lmc_pkg::OP_BRZ) ? (acc_r == '0) : !acc_r[ACC_W-1]) begin
            pc_nxt    = {{(PC_W - ADDR_W){1'b0}}, s1_addr_r};
            ex_status = lmc_pkg::ST_BRANCHED;
          end else begin
            pc_nxt    = pc_inc;
            ex_status = lmc_pkg::ST_ACC_UNCHANGED;
          end
        end
        lmc_pkg::OP_INP: begin
          acc_nxt   = s1_typed_r;
          pc_nxt    = pc_inc;
          ex_status = lmc_pkg::ST_ACC_CHANGED;
        end
        lmc_pkg::OP_OUT: begin
          pc_nxt    = pc_inc;
          ex_status = lmc_pkg::ST_ACC_UNCHANGED;
          ex_print  = 1'b1;
        end
        lmc_pkg::OP_HLT: begin
          ex_status = lmc_pkg::ST_HALT;
        end
        default: begin
          ex_status = lmc_pkg::ST_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pc_r  <= '0;
    end else if (s1_adv) begin
      acc_r <= acc_nxt;
      pc_r  <= pc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= ex_status;
      out_print_r  <= ex_print;
      out_acc_r    <= acc_nxt;
      out_pc_r     <= pc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pc_r, out_acc_r};
  assign out_tuser  = {out_print_r, out_status_r};

  `LMC_ASSERT_NEXT(a_err_holds_state, clk, rst_n,
    s1_adv && (ex_status == lmc_pkg::ST_ERROR),
    $stable(acc_r) && $stable(pc_r), "error step changed accumulator or PC")

  `LMC_ASSERT_SAME(a_wr_only_on_adv, clk, rst_n,
    wr_en, s1_adv && s1_rng && (s1_kind_r || (s1_op_r == lmc_pkg::OP_STA)),
    "memory write outside a preload or STA step")

  `LMC_ASSERT_SAME(a_print_on_out, clk, rst_n,
    out_valid_r && out_print_r, out_status_r == lmc_pkg::ST_ACC_UNCHANGED,
    "print flag with a status other than accumulator unchanged")

endmodule
`default_nettype wire
